// ===== design/positional_list_engine_macros.svh =====
// Assertion macros used by the port-level checker of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
// Types and codes shared by the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;
	typedef logic [2:0]         op_t;
	typedef logic [1:0]         status_t;
	typedef logic signed [31:0] value_t;
	typedef logic signed [15:0] pos_t;
	typedef logic [8:0]         len_t;

	localparam op_t OP_APPEND   = 3'd0;
	localparam op_t OP_INSERT   = 3'd1;
	localparam op_t OP_GET      = 3'd2;
	localparam op_t OP_REMOVE   = 3'd3;
	localparam op_t OP_APPEND_U = 3'd4;
	localparam op_t OP_INSERT_U = 3'd5;
	localparam op_t OP_CLEAR    = 3'd6;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_DUP   = 2'd2;
	localparam status_t ST_FULL  = 2'd3;
endpackage

// ===== design/ple_op_if.sv =====
// Operation channel: valid/ready handshake with one operation item.
`timescale 1ns / 1ps
interface ple_op_if;
	import ple_pkg::*;
	logic   valid;
	logic   ready;
	op_t    operation;
	value_t item_value;
	pos_t   position;

	modport source (output valid, output operation, output item_value, output position,
		input ready);
	modport sink (input valid, input operation, input item_value, input position,
		output ready);
endinterface

// ===== design/ple_res_if.sv =====
// Result channel: valid/ready handshake with one result item.
`timescale 1ns / 1ps
interface ple_res_if;
	import ple_pkg::*;
	logic    valid;
	logic    ready;
	value_t  read_value;
	status_t status;
	len_t    list_length;

	modport source (output valid, output read_value, output status, output list_length,
		input ready);
	modport sink (input valid, input read_value, input status, input list_length,
		output ready);
endinterface

// ===== design/ple_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ple_store #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ple_pkg::value_t       wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output ple_pkg::value_t       rdata
);
	import ple_pkg::*;

	value_t mem [DEPTH];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/ple_ctrl.sv =====
// Sequencer: decodes operations and walks the entry memory for scans and shifts.
`timescale 1ns / 1ps
module ple_ctrl #(
	parameter int CAPACITY = 256,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	ple_op_if.sink          cmd,
	ple_res_if.source       rsp,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output ple_pkg::value_t mem_wdata,
	output logic            mem_re,
	output logic [AW-1:0]   mem_raddr,
	input  ple_pkg::value_t mem_rdata
);
	import ple_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GETW = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SHUP = 3'd3;
	localparam logic [2:0] S_SHDN = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rd_q, rd_d;
	logic [CW-1:0] slot_q, slot_d;
	logic [AW-1:0] raddr_s1, raddr_d;
	logic          pend_s1, pend_d;
	logic          dup_q, dup_d;
	op_t           op_q, op_d;
	value_t        val_q, val_d;
	status_t       status_q, status_d;
	value_t        rdval_q, rdval_d;
	logic          rsp_valid_q, rsp_valid_d;
	value_t        rsp_value_q, rsp_value_d;
	status_t       rsp_status_q, rsp_status_d;
	len_t          rsp_len_q, rsp_len_d;

	logic          full;
	logic [15:0]   pos_mag;
	logic [15:0]   count_w;
	logic          in_range;
	logic [CW-1:0] clamp_slot;
	logic [CW-1:0] rd_inc, rd_dec;

	assign full     = (count_q == CW'(CAPACITY));
	assign pos_mag  = {1'b0, cmd.position[14:0]};
	assign count_w  = 16'(count_q);
	assign in_range = !cmd.position[15] && (pos_mag < count_w);
	assign rd_inc   = rd_q + CW'(1);
	assign rd_dec   = rd_q - CW'(1);

	always_comb begin
		if (cmd.position[15]) begin
			clamp_slot = '0;
		end else if (pos_mag > count_w) begin
			clamp_slot = count_q;
		end else begin
			clamp_slot = cmd.position[CW-1:0];
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.list_length = rsp_len_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rd_d         = rd_q;
		slot_d       = slot_q;
		raddr_d      = raddr_s1;
		pend_d       = pend_s1;
		dup_d        = dup_q;
		op_d         = op_q;
		val_d        = val_q;
		status_d     = status_q;
		rdval_d      = rdval_q;
		rsp_valid_d  = rsp_valid_q;
		rsp_value_d  = rsp_value_q;
		rsp_status_d = rsp_status_q;
		rsp_len_d    = rsp_len_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = val_q;
		mem_re       = 1'b0;
		mem_raddr    = '0;

		if (rsp.ready) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d     = cmd.operation;
					val_d    = cmd.item_value;
					slot_d   = clamp_slot;
					rdval_d  = '0;
					dup_d    = 1'b0;
					pend_d   = 1'b0;
					status_d = ST_OK;
					state_d  = S_DONE;
					case (cmd.operation)
						OP_APPEND: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = cmd.item_value;
								count_d   = count_q + CW'(1);
							end
						end
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								rd_d    = count_q;
								state_d = S_SHUP;
							end
						end
						OP_GET: begin
							if (!in_range) begin
								status_d = ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = cmd.position[AW-1:0];
								state_d   = S_GETW;
							end
						end
						OP_REMOVE: begin
							if (!in_range) begin
								status_d = ST_RANGE;
							end else begin
								rd_d    = cmd.position[CW-1:0] + CW'(1);
								state_d = S_SHDN;
							end
						end
						OP_APPEND_U, OP_INSERT_U: begin
							rd_d    = '0;
							state_d = S_SCAN;
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_GETW: begin
				rdval_d = mem_rdata;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (pend_s1 && (mem_rdata == val_q)) begin
					dup_d = 1'b1;
				end
				if (rd_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_q[AW-1:0];
					raddr_d   = rd_q[AW-1:0];
					pend_d    = 1'b1;
					rd_d      = rd_inc;
				end else begin
					pend_d = 1'b0;
					// The last compare lands in the cycle after the last read.
					if (!pend_s1) begin
						state_d = S_DONE;
						if (dup_q) begin
							status_d = ST_DUP;
						end else if (full) begin
							status_d = ST_FULL;
						end else if (op_q == OP_APPEND_U) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							count_d   = count_q + CW'(1);
						end else begin
							rd_d    = count_q;
							state_d = S_SHUP;
						end
					end
				end
			end
			S_SHUP: begin
				// Entries move up one place, highest first; reads stay below writes.
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = raddr_s1 + AW'(1);
					mem_wdata = mem_rdata;
				end
				if (rd_q > slot_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_dec[AW-1:0];
					raddr_d   = rd_dec[AW-1:0];
					pend_d    = 1'b1;
					rd_d      = rd_dec;
				end else begin
					pend_d = 1'b0;
					if (!pend_s1) begin
						mem_we    = 1'b1;
						mem_waddr = slot_q[AW-1:0];
						mem_wdata = val_q;
						count_d   = count_q + CW'(1);
						state_d   = S_DONE;
					end
				end
			end
			S_SHDN: begin
				// Entries move down one place, lowest first; reads stay above writes.
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = raddr_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (rd_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_q[AW-1:0];
					raddr_d   = rd_q[AW-1:0];
					pend_d    = 1'b1;
					rd_d      = rd_inc;
				end else begin
					pend_d = 1'b0;
					if (!pend_s1) begin
						count_d = count_q - CW'(1);
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d  = 1'b1;
					rsp_value_d  = rdval_q;
					rsp_status_d = status_q;
					rsp_len_d    = len_t'(count_q);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_s1     <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_q         <= rd_d;
		slot_q       <= slot_d;
		raddr_s1     <= raddr_d;
		dup_q        <= dup_d;
		op_q         <= op_d;
		val_q        <= val_d;
		status_q     <= status_d;
		rdval_q      <= rdval_d;
		rsp_value_q  <= rsp_value_d;
		rsp_status_q <= rsp_status_d;
		rsp_len_q    <= rsp_len_d;
	end
endmodule

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: entry memory and sequencer.
//
// Usage: operation items arrive on cmd (operation, item_value, position) and
// each one gives exactly one result item on rsp (read_value, status,
// list_length). Both channels move an item when valid and ready are high at
// a rising edge of clk.
// The block works on one operation at a time. cmd.ready is high while the
// sequencer is idle, also while a finished result still waits in the output
// register. Append, clear, the unused code and a range or full status found
// at once go straight to the result; get waits on one registered read;
// remove at position p moves each entry above p down one place; insert at
// slot s moves each entry from s onward up one place, then writes the new
// item; the unique forms first scan the whole list for a duplicate. The
// scan and the shifts walk the entry memory one entry per cycle, through
// its single read port and single write port. A stalled receiver holds the
// result register; the next operation may then be worked on but waits at its
// end until the register frees up. Reset (arst_n low) empties the list and
// drops any pending result; the memory contents are not cleared, since only
// entries below the length are ever read.
`timescale 1ns / 1ps
module positional_list_engine #(
	parameter int CAPACITY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_op_if.sink    cmd,
	ple_res_if.source rsp
);
	import ple_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	value_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	value_t        mem_rdata;

	ple_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ple_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);
endmodule

// ===== design/ple_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"
module ple_checker #(
	parameter int CAPACITY = 256
) (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input ple_pkg::value_t  rsp_read_value,
	input ple_pkg::status_t rsp_status,
	input ple_pkg::len_t    rsp_list_length
);
	import ple_pkg::*;

	localparam len_t CAP_LEN = len_t'(CAPACITY);

	// A result item stays offered until it is taken.
	`PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// Only a successful get carries a value, so any failure must read zero.
	`PLE_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_status != ST_OK), rsp_read_value == '0, "value on failed item")

	// A full status can only come from a list at capacity.
	`PLE_ASSERT_NOW(a_full_len, rsp_valid && (rsp_status == ST_FULL), rsp_list_length == CAP_LEN, "full at short length")

	// The reported length never passes capacity while it fits the field.
	`PLE_ASSERT_NOW(a_len_cap, rsp_valid, (CAPACITY > 511) || (rsp_list_length <= CAP_LEN), "length above capacity")
endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_status      (rsp.status),
	.rsp_list_length (rsp.list_length)
);

// ===== verif/positional_list_engine_checker.sv =====
// Passive checker for the positional list engine: tracks the list and compares each result.
`timescale 1ns / 1ps
module positional_list_engine_checker #(
	parameter int CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	ple_op_if    cmd,
	ple_res_if   rsp,
	output int   fail_count,
	output int   pending_results,
	output int   model_length
);
	import ple_pkg::*;

	typedef struct packed {
		value_t  read_value;
		status_t status;
		len_t    list_length;
	} list_result_t;

	value_t       list_mem [CAPACITY];
	int           stored_count;
	int           mismatch_count = 0;
	list_result_t expected_results [$];
	list_result_t want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		$display("%0t ns: %s got %0h, expected %0h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Applies one operation to the tracked list and returns the result it should give.
	function automatic list_result_t apply_list_operation(input op_t op, input value_t v,
		input pos_t p);
		list_result_t outcome;
		int           slot;
		bit           dup;
		outcome.read_value = '0;
		outcome.status = ST_OK;
		dup = 1'b0;
		if (op == OP_APPEND_U || op == OP_INSERT_U) begin
			for (int i = 0; i < stored_count; i++)
				if (list_mem[i] == v)
					dup = 1'b1;
		end
		if (op == OP_APPEND || op == OP_APPEND_U)
			slot = stored_count;
		else if (p <= 0)
			slot = 0;
		else if (int'(p) > stored_count)
			slot = stored_count;
		else
			slot = int'(p);
		case (op)
			OP_APPEND, OP_INSERT, OP_APPEND_U, OP_INSERT_U: begin
				// The duplicate check wins over a full list.
				if (dup)
					outcome.status = ST_DUP;
				else if (stored_count >= CAPACITY)
					outcome.status = ST_FULL;
				else begin
					for (int i = stored_count; i > slot; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[slot] = v;
					stored_count++;
				end
			end
			OP_GET: begin
				if (p < 0 || int'(p) >= stored_count)
					outcome.status = ST_RANGE;
				else
					outcome.read_value = list_mem[int'(p)];
			end
			OP_REMOVE: begin
				if (p < 0 || int'(p) >= stored_count)
					outcome.status = ST_RANGE;
				else begin
					for (int i = int'(p); i + 1 < stored_count; i++)
						list_mem[i] = list_mem[i + 1];
					stored_count--;
				end
			end
			OP_CLEAR: stored_count = 0;
			default: ;
		endcase
		outcome.list_length = len_t'(stored_count);
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count = 0;
			expected_results.delete();
			pending_results <= 0;
			model_length <= 0;
			fail_count <= mismatch_count;
		end else begin
			// Results are retired before new operations are queued, so a stray
			// result can never match an expectation made at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result, status", 32'(rsp.status), '0);
				else begin
					want = expected_results.pop_front();
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.list_length !== want.list_length)
						report_mismatch("list_length", 32'(rsp.list_length),
							32'(want.list_length));
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(apply_list_operation(cmd.operation,
					cmd.item_value, cmd.position));
			pending_results <= expected_results.size();
			model_length <= stored_count;
			fail_count <= mismatch_count;
		end
	end
endmodule

// ===== verif/positional_list_engine_test.sv =====
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module positional_list_engine_test;
	import ple_pkg::*;

	localparam int  CAPACITY       = 256;
	localparam int  TARGET_ITEMS   = 1300;
	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  DRAIN_CYCLES   = 600;
	localparam op_t OP_SPARE       = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ple_op_if  op_ch ();
	ple_res_if res_ch ();

	int     fail_count;
	int     pending_results;
	int     model_length;
	int     items_sent;
	int     stall_left = 0;
	int     idle_cycles = 0;
	int     fills_done;
	int     episode;
	bit     quiet;
	value_t value_pool [16];
	int     pool_slot;

	always #5 clk = ~clk;

	positional_list_engine #(.CAPACITY(CAPACITY)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (op_ch.sink),
		.rsp    (res_ch.source)
	);

	positional_list_engine_checker #(.CAPACITY(CAPACITY)) list_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (op_ch),
		.rsp             (res_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.model_length    (model_length)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 1;
		if (r < 85)
			return $urandom_range(2, 4);
		if (r < 97)
			return $urandom_range(5, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic value_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		// Reusing recent values is what makes the unique forms find duplicates.
		if (r < 4)
			return value_pool[$urandom_range(0, 15)];
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return value_t'(32'h7FFF_FFFF);
				1: return value_t'(32'h8000_0000);
				2: return value_t'(32'h0);
				default: return value_t'(32'hFFFF_FFFF);
			endcase
		end
		return value_t'($urandom);
	endfunction

	function automatic pos_t pick_position(input int len);
		case ($urandom_range(0, 9))
			0: return pos_t'(0 - int'($urandom_range(1, 3)));
			1: return pos_t'($urandom);
			2: return pos_t'(len);
			3: return pos_t'(len - 1);
			4: return pos_t'(len + 1);
			default: return pos_t'($urandom_range(0, len));
		endcase
	endfunction

	function automatic op_t pick_churn_op(input int len, input int len_cap);
		int r;
		r = $urandom_range(0, 99);
		if (len > len_cap && r < 40)
			return OP_REMOVE;
		if (r < 18)
			return OP_APPEND;
		if (r < 32)
			return OP_INSERT;
		if (r < 50)
			return OP_GET;
		if (r < 66)
			return OP_REMOVE;
		if (r < 78)
			return OP_APPEND_U;
		if (r < 90)
			return OP_INSERT_U;
		if (r < 93)
			return OP_CLEAR;
		if (r < 95)
			return OP_SPARE;
		return OP_GET;
	endfunction

	// Returns at the edge where the item is taken, with valid still high.
	task automatic send_item(input op_t op, input value_t v, input pos_t p);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			op_ch.valid <= 1'b0;
			repeat (random_gap()) @(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.operation <= op;
		op_ch.item_value <= v;
		op_ch.position <= p;
		do
			@(posedge clk);
		while (!op_ch.ready);
		items_sent++;
		if (op == OP_APPEND || op == OP_INSERT || op == OP_APPEND_U || op == OP_INSERT_U) begin
			value_pool[pool_slot] = v;
			pool_slot = (pool_slot + 1) % 16;
		end
	endtask

	task automatic drain_results();
		op_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results != 0);
	endtask

	task automatic churn_episode(input int count, input int len_cap);
		repeat (count)
			send_item(pick_churn_op(model_length, len_cap), pick_value(),
				pick_position(model_length));
	endtask

	// Fills the list to capacity, then works on it while it is nearly full.
	task automatic fill_episode();
		while (model_length < CAPACITY) begin
			if ($urandom_range(0, 4) == 0)
				send_item(OP_INSERT, pick_value(), pick_position(model_length));
			else
				send_item(OP_APPEND, pick_value(), pick_position(model_length));
		end
		churn_episode(40, CAPACITY);
		fills_done++;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= random_gap() - 1;
		end else
			res_ch.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("positional_list_engine: mismatch");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		op_ch.valid <= 1'b0;
		op_ch.operation <= OP_GET;
		op_ch.item_value <= '0;
		op_ch.position <= '0;
		items_sent = 0;
		fills_done = 0;
		pool_slot = 0;
		quiet = 1'b0;
		for (int i = 0; i < 16; i++)
			value_pool[i] = value_t'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, clamped insert positions, duplicates, range limits, clear.
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h0));
		send_item(OP_REMOVE, value_t'(32'h0), pos_t'(16'h0));
		send_item(OP_APPEND, value_t'(32'h7FFF_FFFF), pos_t'(16'h0));
		send_item(OP_APPEND, value_t'(32'h8000_0000), pos_t'(16'h0));
		send_item(OP_INSERT, value_t'(32'h0), pos_t'(16'h8000));
		send_item(OP_INSERT, value_t'(32'hFFFF_FFFF), pos_t'(16'h7FFF));
		send_item(OP_INSERT, value_t'(32'h5A5A_5A5A), pos_t'(16'h2));
		send_item(OP_APPEND_U, value_t'(32'h7FFF_FFFF), pos_t'(16'h0));
		send_item(OP_INSERT_U, value_t'(32'h1234_5678), pos_t'(16'h1));
		send_item(OP_INSERT_U, value_t'(32'hFFFF_FFFF), pos_t'(16'h0));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h0));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h5));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h6));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'hFFFF));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h7FFF));
		send_item(OP_REMOVE, value_t'(32'h0), pos_t'(16'h8000));
		send_item(OP_REMOVE, value_t'(32'h0), pos_t'(16'h5));
		send_item(OP_REMOVE, value_t'(32'h0), pos_t'(16'h0));
		send_item(OP_REMOVE, value_t'(32'h0), pos_t'(16'h1));
		send_item(OP_SPARE, value_t'(32'hDEAD_BEEF), pos_t'(16'h1));
		send_item(OP_APPEND_U, value_t'(32'h00C0_FFEE), pos_t'(16'h0));
		send_item(OP_CLEAR, value_t'(32'h0), pos_t'(16'h0));
		send_item(OP_GET, value_t'(32'h0), pos_t'(16'h0));
		drain_results();

		episode = 0;
		while (items_sent < TARGET_ITEMS) begin
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0)
				drain_results();
			if (episode == 3 || (fills_done < 3 && $urandom_range(0, 9) == 0))
				fill_episode();
			else
				churn_episode($urandom_range(20, 60), $urandom_range(4, 32));
			episode++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("positional_list_engine: match");
		else
			$display("positional_list_engine: mismatch");
		$finish;
	end
endmodule

// ===== positional_list_engine.f =====
+incdir+design
design/ple_pkg.sv
design/ple_op_if.sv
design/ple_res_if.sv
design/ple_store.sv
design/ple_ctrl.sv
design/positional_list_engine.sv
design/ple_checker.sv
verif/positional_list_engine_checker.sv
verif/positional_list_engine_test.sv
